// ----- src/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int FUNC_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int IDX_W     = 11;
  localparam int COL_OUT_W = 7;
  localparam int ROW_OUT_W = 5;
  localparam int CELL_W    = 16;

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 32;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_NULL    = 8'h00;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_BLANK   = 8'h20;

  localparam logic [CELL_W-1:0] RESET_CELL       = 16'h0720;
  localparam logic [CHAR_W-1:0] CLEAR_ATTR_RESET = 8'h07;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_NULL,
    OP_CLEAR,
    OP_READ,
    OP_READ_OOR,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } cmd_t;

  typedef struct packed {
    logic [CELL_W-1:0]    cell_data;
    logic                 scrolled;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;
  } res_t;

endpackage

// ----- src/tcw_front.sv -----
// ----------------------------------------------------------------------------
// tcw_front
// Input side: unpacks stream words and classifies them into commands.
// ----------------------------------------------------------------------------
module tcw_front #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [tcw_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  input  logic [tcw_pkg::FUNC_W-1:0]     s_axis_tuser_i,
  input  logic                           run_i,
  output logic                           cmd_valid_o,
  input  logic                           cmd_ready_i,
  output tcw_pkg::cmd_t                  cmd_o
);

  localparam int CELLS = COLUMNS * ROWS;

  logic [tcw_pkg::CHAR_W-1:0] char_code;
  logic [tcw_pkg::IDX_W-1:0]  cell_index;

  assign char_code  = s_axis_tdata_i[tcw_pkg::CHAR_W-1:0];
  assign cell_index = s_axis_tdata_i[tcw_pkg::CHAR_W +: tcw_pkg::IDX_W];

  // hold off the stream until the store has been initialized
  assign s_axis_tready_o = cmd_ready_i && run_i;
  assign cmd_valid_o     = s_axis_tvalid_i && run_i;

  always_comb begin
    cmd_o.char_code  = char_code;
    cmd_o.cell_index = cell_index;
    case (s_axis_tuser_i)
      tcw_pkg::FUNC_PUT: begin
        if (char_code == tcw_pkg::CHAR_NULL) begin
          cmd_o.op = tcw_pkg::OP_NULL;
        end else if (char_code == tcw_pkg::CHAR_NEWLINE) begin
          cmd_o.op = tcw_pkg::OP_NEWLINE;
        end else begin
          cmd_o.op = tcw_pkg::OP_PUT;
        end
      end
      tcw_pkg::FUNC_CLEAR: cmd_o.op = tcw_pkg::OP_CLEAR;
      tcw_pkg::FUNC_READ: begin
        if (32'(cell_index) < CELLS) begin
          cmd_o.op = tcw_pkg::OP_READ;
        end else begin
          cmd_o.op = tcw_pkg::OP_READ_OOR;
        end
      end
      default: cmd_o.op = tcw_pkg::OP_NOP;
    endcase
  end

endmodule

// ----- src/tcw_queue.sv -----
// ----------------------------------------------------------------------------
// tcw_queue
// Short command FIFO between the classifier and the screen engine.
// ----------------------------------------------------------------------------
module tcw_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tcw_pkg::cmd_t in_cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output tcw_pkg::cmd_t out_cmd_o
);

  localparam int PW = (tcw_pkg::QUEUE_DEPTH > 1) ? $clog2(tcw_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(tcw_pkg::QUEUE_DEPTH + 1);

  tcw_pkg::cmd_t  slots_q [tcw_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;
  logic           push, pop;

  assign in_ready_o  = (count_q != CW'(tcw_pkg::QUEUE_DEPTH));
  assign out_valid_o = (count_q != '0);
  assign out_cmd_o   = slots_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(tcw_pkg::QUEUE_DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
    end
    if (push && !pop) begin
      count_d = CW'(count_q + 1'b1);
    end else if (pop && !push) begin
      count_d = CW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= in_cmd_i;
    end
  end

endmodule

// ----- src/tcw_back.sv -----
// ----------------------------------------------------------------------------
// tcw_back
// Screen engine: cell RAM, cursor, fill and scroll sweeps, result register.
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tcw_pkg::CHAR_W-1:0]  cfg_data_i,
  output logic                        run_o,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  tcw_pkg::cmd_t               cmd_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output tcw_pkg::res_t               res_o
);

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int AW        = $clog2(CELLS);
  localparam int NW        = $clog2(CELLS + 1);
  localparam int CW        = $clog2(COLUMNS);
  localparam int RW        = $clog2(ROWS);
  localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT_WR,
    ST_READ,
    ST_FILL,
    ST_SCROLL
  } state_e;

  state_e                       state_q, state_d;
  logic [NW-1:0]                cnt_q, cnt_d;
  logic [CW-1:0]                col_q, col_d;
  logic [RW-1:0]                row_q, row_d;
  logic [tcw_pkg::CHAR_W-1:0]   char_q, char_d;
  logic [tcw_pkg::CHAR_W-1:0]   clear_attr_q;
  logic                         res_valid_q, res_valid_d;
  tcw_pkg::res_t                res_q, res_d;

  logic [tcw_pkg::CELL_W-1:0]   mem_q [CELLS];
  logic [tcw_pkg::CELL_W-1:0]   rdata_q;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [tcw_pkg::CELL_W-1:0]   mem_wdata;
  logic [AW-1:0]                mem_raddr;

  logic                         slot_free;
  logic [AW-1:0]                pos;
  logic [NW-1:0]                prev_cnt;

  assign cfg_ready_o = 1'b1;
  assign run_o       = (state_q != ST_INIT);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign slot_free = !res_valid_q || res_ready_i;
  assign pos       = AW'(AW'(row_q) * AW'(COLUMNS) + AW'(col_q));
  assign prev_cnt  = NW'(cnt_q - 1'b1);
  assign cmd_ready_o = (state_q == ST_IDLE) && slot_free;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    col_d       = col_q;
    row_d       = row_q;
    char_d      = char_q;
    res_valid_d = res_valid_q && !res_ready_i;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = '0;

    case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cnt_q);
        mem_wdata = tcw_pkg::RESET_CELL;
        if (cnt_q == NW'(CELLS - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = NW'(cnt_q + 1'b1);
        end
      end

      ST_IDLE: begin
        if (cmd_valid_i && slot_free) begin
          res_d.cursor_col = tcw_pkg::COL_OUT_W'(col_q);
          res_d.cursor_row = tcw_pkg::ROW_OUT_W'(row_q);
          res_d.scrolled   = 1'b0;
          res_d.cell_data  = '0;
          case (cmd_i.op)
            tcw_pkg::OP_PUT: begin
              mem_raddr = pos;
              char_d    = cmd_i.char_code;
              state_d   = ST_PUT_WR;
            end
            tcw_pkg::OP_NEWLINE: begin
              col_d = '0;
              if (row_q == RW'(ROWS - 1)) begin
                cnt_d   = '0;
                state_d = ST_SCROLL;
              end else begin
                row_d            = RW'(row_q + 1'b1);
                res_d.cursor_col = '0;
                res_d.cursor_row = tcw_pkg::ROW_OUT_W'(RW'(row_q + 1'b1));
                res_valid_d      = 1'b1;
              end
            end
            tcw_pkg::OP_CLEAR: begin
              cnt_d   = '0;
              state_d = ST_FILL;
            end
            tcw_pkg::OP_READ: begin
              mem_raddr = AW'(cmd_i.cell_index);
              state_d   = ST_READ;
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end

      ST_PUT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos;
        mem_wdata = {rdata_q[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W], char_q};
        if (col_q == CW'(COLUMNS - 1)) begin
          col_d = '0;
          if (row_q == RW'(ROWS - 1)) begin
            cnt_d   = '0;
            state_d = ST_SCROLL;
          end else begin
            row_d            = RW'(row_q + 1'b1);
            res_d.cursor_col = '0;
            res_d.cursor_row = tcw_pkg::ROW_OUT_W'(RW'(row_q + 1'b1));
            res_valid_d      = 1'b1;
            state_d          = ST_IDLE;
          end
        end else begin
          col_d            = CW'(col_q + 1'b1);
          res_d.cursor_col = tcw_pkg::COL_OUT_W'(CW'(col_q + 1'b1));
          res_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end

      ST_READ: begin
        res_d.cell_data = rdata_q;
        res_valid_d     = 1'b1;
        state_d         = ST_IDLE;
      end

      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cnt_q);
        mem_wdata = {clear_attr_q, tcw_pkg::CHAR_BLANK};
        if (cnt_q == NW'(CELLS - 1)) begin
          cnt_d            = '0;
          col_d            = '0;
          row_d            = '0;
          res_d.cursor_col = '0;
          res_d.cursor_row = '0;
          res_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end else begin
          cnt_d = NW'(cnt_q + 1'b1);
        end
      end

      ST_SCROLL: begin
        // read the source of step cnt, write back the cell fetched for step cnt-1
        if (cnt_q < NW'(LAST_BASE)) begin
          mem_raddr = AW'(NW'(cnt_q + NW'(COLUMNS)));
        end else if (cnt_q < NW'(CELLS)) begin
          mem_raddr = AW'(cnt_q);
        end
        if (cnt_q != '0) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(prev_cnt);
          if (prev_cnt < NW'(LAST_BASE)) begin
            mem_wdata = rdata_q;
          end else begin
            mem_wdata = {rdata_q[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W], tcw_pkg::CHAR_BLANK};
          end
        end
        if (cnt_q == NW'(CELLS)) begin
          cnt_d            = '0;
          col_d            = '0;
          row_d            = RW'(ROWS - 1);
          res_d.cursor_col = '0;
          res_d.cursor_row = tcw_pkg::ROW_OUT_W'(RW'(ROWS - 1));
          res_d.scrolled   = 1'b1;
          res_d.cell_data  = '0;
          res_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end else begin
          cnt_d = NW'(cnt_q + 1'b1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_INIT;
      cnt_q        <= '0;
      col_q        <= '0;
      row_q        <= '0;
      char_q       <= '0;
      clear_attr_q <= tcw_pkg::CLEAR_ATTR_RESET;
      res_valid_q  <= 1'b0;
      res_q        <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      col_q       <= col_d;
      row_q       <= row_d;
      char_q      <= char_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
      if (cfg_valid_i) begin
        clear_attr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

endmodule

// ----- src/text_console_writer_top.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_top
// Character-cell console: cell RAM, cursor, put, clear, read and scroll.
// ----------------------------------------------------------------------------
// After reset the block writes 0x0720 to every cell and accepts no word
// until that pass ends. A command queue of two words decouples the input
// stream from the screen engine, which runs one command at a time against a
// single-write, single-read cell RAM with registered read data. A put of a
// printable byte and a read first read the RAM, then write the cell or give
// the result; a null byte, a newline that does not scroll, an unused command
// and an out-of-range read give their result directly. Clear fills every
// cell, and a put or newline that scrolls adds a copy sweep, one cell per
// cycle. Every command gives exactly one result word, held in an output
// register until taken.
module text_console_writer_top #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tcw_pkg::CHAR_W-1:0]    cfg_data_i,      // clear_attribute
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [tcw_pkg::S_TDATA_W-1:0] s_axis_tdata_i,  // char_code, cell_index
  input  logic [tcw_pkg::FUNC_W-1:0]    s_axis_tuser_i,  // func
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [tcw_pkg::M_TDATA_W-1:0] m_axis_tdata_o   // cursor_col, cursor_row,
                                                         // scrolled, cell_data
);

  localparam int RES_W = $bits(tcw_pkg::res_t);

  logic          run;
  logic          front_valid, front_ready;
  tcw_pkg::cmd_t front_cmd;
  logic          queue_valid, queue_ready;
  tcw_pkg::cmd_t queue_cmd;
  tcw_pkg::res_t res;

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .run_i           (run),
    .cmd_valid_o     (front_valid),
    .cmd_ready_i     (front_ready),
    .cmd_o           (front_cmd)
  );

  tcw_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_cmd_i    (front_cmd),
    .out_valid_o (queue_valid),
    .out_ready_i (queue_ready),
    .out_cmd_o   (queue_cmd)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .run_o       (run),
    .cmd_valid_i (queue_valid),
    .cmd_ready_o (queue_ready),
    .cmd_i       (queue_cmd),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  assign m_axis_tdata_o = {{(tcw_pkg::M_TDATA_W - RES_W){1'b0}}, res};

endmodule

// ----- sim/text_console_writer_top_tb.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_top_tb
// Self-checking testbench of the text console writer.
// ----------------------------------------------------------------------------
// A queue of commands, filled phase by phase, feeds a stream driver. Each word
// accepted by the block runs through a cycle-free console predictor (cell
// store, cursor, scroll, clear attribute), and the predicted report is queued.
// A monitor compares every report word field by field with the oldest
// prediction. Phases differ in source and sink idling and in the clear
// attribute. Random traffic is mostly cleared screens filled line by line
// to about the last row and often past it, so that scrolls, wraps and reads
// of moved cells are exercised, mixed with unstructured commands.
// ----------------------------------------------------------------------------
module text_console_writer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS  = tcw_pkg::COLUMNS_DEF;
  localparam int LINES = tcw_pkg::ROWS_DEF;
  localparam int CELLS = COLS * LINES;

  localparam int FW  = tcw_pkg::FUNC_W;
  localparam int CHW = tcw_pkg::CHAR_W;
  localparam int IW  = tcw_pkg::IDX_W;
  localparam int SW  = tcw_pkg::S_TDATA_W;
  localparam int MW  = tcw_pkg::M_TDATA_W;
  localparam int CLW = tcw_pkg::CELL_W;

  localparam logic [FW-1:0] FUNC_UNUSED = 2'd3;

  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS  = 260;
  localparam int MAX_REPORTS  = 10;
  localparam int RES_W        = $bits(tcw_pkg::res_t);
  localparam int PAD_W        = MW - RES_W;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [FW-1:0]  func;
    logic [CHW-1:0] char_code;
    logic [IW-1:0]  cell_index;
  } console_cmd_t;

  logic            clk_i;
  logic            rst_ni     = 1'b0;
  logic            cfg_valid  = 1'b0;
  logic [CHW-1:0]  cfg_data   = '0;
  logic            s_valid    = 1'b0;
  logic [SW-1:0]   s_tdata    = '0;
  logic [FW-1:0]   s_tuser    = '0;
  logic            m_ready    = 1'b0;
  logic            cfg_ready_o;
  logic            s_axis_tready_o;
  logic            m_axis_tvalid_o;
  logic [MW-1:0]   m_axis_tdata_o;

  // console predictor state
  logic [CLW-1:0]                   screen_model [CELLS];
  logic [tcw_pkg::COL_OUT_W-1:0]    col_model;
  logic [tcw_pkg::ROW_OUT_W-1:0]    row_model;
  logic [CHW-1:0]                   clear_attr_model;

  console_cmd_t     cmd_backlog [$];
  console_cmd_t     cmd_on_bus;
  tcw_pkg::res_t    cursor_reports [$];
  tcw_pkg::res_t    seen_res;
  tcw_pkg::res_t    want_res;
  logic [PAD_W-1:0] seen_pad;

  idle_mode_e idle_mode = IDLE_NONE;
  logic       src_gap;
  int         generated    = 0;
  int         accepted     = 0;
  int         mismatches   = 0;
  int         scroll_count = 0;
  int         clear_count  = 0;
  int         read_count   = 0;
  int         cfg_writes   = 0;
  int         quiet_cycles = 0;

  text_console_writer_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Apply one command to the console state and return the report it gives.
  function automatic tcw_pkg::res_t console_apply(console_cmd_t c);
    tcw_pkg::res_t r;
    int            pos;
    r = '0;
    if (c.func == tcw_pkg::FUNC_PUT && c.char_code != tcw_pkg::CHAR_NULL) begin
      if (c.char_code == tcw_pkg::CHAR_NEWLINE) begin
        row_model = row_model + 1'b1;
        col_model = '0;
      end else begin
        pos = int'(row_model) * COLS + int'(col_model);
        if (pos < CELLS) begin
          screen_model[pos] = {screen_model[pos][CLW-1:CHW], c.char_code};
        end
        col_model = col_model + 1'b1;
      end
      if (col_model >= COLS) begin
        row_model = row_model + 1'b1;
        col_model = '0;
      end
      if (row_model >= LINES) begin
        for (int i = 0; i < CELLS - COLS; i++) begin
          screen_model[i] = screen_model[i + COLS];
        end
        // blank the characters of the last row, keep its attributes
        for (int i = CELLS - COLS; i < CELLS; i++) begin
          screen_model[i][CHW-1:0] = tcw_pkg::CHAR_BLANK;
        end
        row_model  = tcw_pkg::ROW_OUT_W'(LINES - 1);
        r.scrolled = 1'b1;
        scroll_count++;
      end
    end else if (c.func == tcw_pkg::FUNC_CLEAR) begin
      for (int i = 0; i < CELLS; i++) begin
        screen_model[i] = {clear_attr_model, tcw_pkg::CHAR_BLANK};
      end
      col_model = '0;
      row_model = '0;
      clear_count++;
    end else if (c.func == tcw_pkg::FUNC_READ) begin
      if (c.cell_index < CELLS) begin
        r.cell_data = screen_model[c.cell_index];
      end
      read_count++;
    end
    r.cursor_col = col_model;
    r.cursor_row = row_model;
    return r;
  endfunction

  task automatic push_cmd(logic [FW-1:0] func, logic [CHW-1:0] ch,
                          logic [IW-1:0] idx);
    console_cmd_t c;
    c.func       = func;
    c.char_code  = ch;
    c.cell_index = idx;
    cmd_backlog.push_back(c);
    generated++;
  endtask

  // Mostly cells near the line starts and ends, sometimes any 11-bit index, also out of range.
  function automatic logic [IW-1:0] pick_cell();
    int col;
    if ($urandom_range(0, 2) == 0) begin
      return IW'($urandom_range(0, 2**IW - 1));
    end
    col = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4)
                                      : $urandom_range(COLS - 3, COLS - 1);
    return IW'($urandom_range(0, LINES - 1) * COLS + col);
  endfunction

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || s_valid || cursor_reports.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Stream driver: predict on acceptance, then present the next word.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= '0;
    end else begin
      if (s_valid && s_axis_tready_o) begin
        cursor_reports.push_back(console_apply(cmd_on_bus));
        accepted++;
      end
      if (!s_valid || s_axis_tready_o) begin
        src_gap = (idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 55) ||
                  (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 32);
        if (cmd_backlog.size() != 0 && !src_gap) begin
          cmd_on_bus = cmd_backlog.pop_front();
          s_valid <= 1'b1;
          s_tdata <= {{(SW - CHW - IW){1'b0}},
                      cmd_on_bus.cell_index, cmd_on_bus.char_code};
          s_tuser <= cmd_on_bus.func;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Report monitor.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      seen_res = m_axis_tdata_o[RES_W-1:0];
      seen_pad = m_axis_tdata_o[MW-1:RES_W];
      if (cursor_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected report word %h at %0t", m_axis_tdata_o, $realtime);
        end
      end else begin
        want_res = cursor_reports.pop_front();
        if (seen_res.cursor_col != want_res.cursor_col ||
            seen_res.cursor_row != want_res.cursor_row ||
            seen_res.scrolled   != want_res.scrolled   ||
            seen_res.cell_data  != want_res.cell_data  || seen_pad != '0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch at %0t: expected col %0d row %0d scrolled %0b cell %h pad 0",
                     $realtime, want_res.cursor_col, want_res.cursor_row,
                     want_res.scrolled, want_res.cell_data);
            $display("                  got col %0d row %0d scrolled %0b cell %h pad %h",
                     seen_res.cursor_col, seen_res.cursor_row, seen_res.scrolled,
                     seen_res.cell_data, seen_pad);
          end
        end
      end
    end
    m_ready <= !((idle_mode == IDLE_RECEIVER && $urandom_range(0, 99) < 55) ||
                 (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 32));
  end

  // Watchdog: count cycles without any handshake.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d reports pending",
               quiet_cycles, cursor_reports.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [CHW-1:0] attr;
    int             target;
    int             line_total;
    int             run_len;

    for (int i = 0; i < CELLS; i++) begin
      screen_model[i] = tcw_pkg::RESET_CELL;
    end
    col_model        = '0;
    row_model        = '0;
    clear_attr_model = tcw_pkg::CLEAR_ATTR_RESET;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: field extremes, every command, null, out-of-range read
    push_cmd(tcw_pkg::FUNC_PUT, 8'hFF, '0);
    push_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_NULL, '1);
    push_cmd(tcw_pkg::FUNC_READ, '0, IW'(0));
    push_cmd(tcw_pkg::FUNC_READ, '0, IW'(1));
    push_cmd(tcw_pkg::FUNC_READ, 8'hFF, IW'(CELLS - 1));
    push_cmd(tcw_pkg::FUNC_READ, '0, IW'(CELLS));
    push_cmd(tcw_pkg::FUNC_READ, 8'hFF, '1);
    push_cmd(FUNC_UNUSED, 8'hFF, '1);
    push_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_NEWLINE, '0);
    push_cmd(tcw_pkg::FUNC_PUT, 8'h80, '0);
    push_cmd(tcw_pkg::FUNC_PUT, 8'h7F, '0);
    push_cmd(tcw_pkg::FUNC_READ, '0, IW'(COLS));
    push_cmd(tcw_pkg::FUNC_READ, '0, IW'(COLS + 1));
    push_cmd(tcw_pkg::FUNC_CLEAR, 8'hFF, '1);
    push_cmd(tcw_pkg::FUNC_READ, '0, IW'(0));
    push_cmd(tcw_pkg::FUNC_READ, '0, IW'(COLS));
    push_cmd(tcw_pkg::FUNC_PUT, 8'h55, '0);
    push_cmd(tcw_pkg::FUNC_PUT, 8'hAA, '0);
    push_cmd(tcw_pkg::FUNC_READ, '0, IW'(1));
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      idle_mode = idle_mode_e'(phase);
      case (phase)
        0: attr = 8'h00;
        1: attr = 8'hFF;
        default: attr = CHW'($urandom_range(1, 254));
      endcase

      @(posedge clk_i);
      cfg_valid <= 1'b1;
      cfg_data  <= attr;
      do @(posedge clk_i); while (!cfg_ready_o);
      clear_attr_model = attr;
      cfg_writes++;
      cfg_valid <= 1'b0;
      @(negedge clk_i);

      target = generated + PHASE_ITEMS;
      while (generated < target) begin
        if ($urandom_range(0, 99) < 8) begin
          push_cmd(FW'($urandom_range(0, 3)), CHW'($urandom_range(0, 255)),
                   IW'($urandom_range(0, 2**IW - 1)));
        end else begin
          // clear, then fill LINES-2 to LINES+3 lines, often past the last row
          push_cmd(tcw_pkg::FUNC_CLEAR, CHW'($urandom), IW'($urandom));
          line_total = LINES - 2 + $urandom_range(0, 5);
          for (int ln = 0; ln < line_total; ln++) begin
            run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(COLS - 2, COLS + 2)
                                                   : $urandom_range(0, 3);
            for (int k = 0; k < run_len; k++) begin
              push_cmd(tcw_pkg::FUNC_PUT, CHW'($urandom_range(1, 255)), IW'($urandom));
              if ($urandom_range(0, 15) == 0) begin
                push_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_NULL, IW'($urandom));
              end
            end
            if ($urandom_range(0, 5) == 0) begin
              push_cmd(tcw_pkg::FUNC_READ, CHW'($urandom), pick_cell());
            end
            push_cmd(tcw_pkg::FUNC_PUT, tcw_pkg::CHAR_NEWLINE, IW'($urandom));
          end
          repeat (8) push_cmd(tcw_pkg::FUNC_READ, CHW'($urandom), pick_cell());
        end
      end
      wait_drained();
    end

    mismatches += cursor_reports.size();
    $display("Ran %0d commands under four idle mixes and %0d clear attributes:",
             accepted, cfg_writes);
    $display("%0d scrolls, %0d clears, %0d reads, %0d mismatches",
             scroll_count, clear_count, read_count, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/tcw_pkg.sv
src/tcw_front.sv
src/tcw_queue.sv
src/tcw_back.sv
src/text_console_writer_top.sv
sim/text_console_writer_top_tb.sv
